@@ src/vlc_pkg.sv @@
// Shared types, constants and register codes of the letter cipher.
`default_nettype none
package vlc_pkg;

    localparam int KEY_BYTES_DEF = 32;
    localparam int KEY_REG_BYTES = 32;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_LEN_W     = 6;
    localparam int APB_ADDR_W    = 6;
    localparam int APB_DATA_W    = 64;
    localparam int QUEUE_DEPTH   = 2;
    localparam int ALPHA         = 26;

    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;

    localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd4;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_UPPER = 2'd1,
        CLS_LOWER = 2'd2
    } t_cls;

    // One classified request waiting for the back end.
    typedef struct packed {
        logic       action;
        t_cls       cls;
        logic [7:0] ch;
        logic [4:0] off;
        logic [4:0] shift;
    } t_work;

endpackage
`default_nettype wire

@@ src/vlc_ifs.sv @@
// Request and result stream interfaces of the letter cipher.
`default_nettype none
interface vlc_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic       restart;
    logic [7:0] in_char;

    modport source (output valid, output action, output restart, output in_char, input ready);
    modport sink   (input valid, input action, input restart, input in_char, output ready);
endinterface

interface vlc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;

    modport source (output valid, output out_char, input ready);
    modport sink   (input valid, input out_char, output ready);
endinterface
`default_nettype wire

@@ src/vigenere_letter_cipher.sv @@
// Top level of the repeating-key letter shift cipher with its register port.
//
//  channel   direction  handshake        payload
//  i_req     in         valid / ready    action, restart, in_char
//  o_rsp     out        valid / ready    out_char
//  APB       in/out     psel / penable   key_word_0..3, key_length (64-bit data)
//
// One request per cycle sustained while the queue has room; a byte taken
// at i_req passes a queue slot, then the result register, to reach o_rsp.
// Reset (i_rst_n low, synchronous) clears the key words, sets key_length to 1
// and the key position to 0; the queue and result register come up empty.
// The queue decouples the two halves: the front stops taking requests only
// when both queue slots are full, the back holds its result while o_rsp stalls.
`default_nettype none
module vigenere_letter_cipher #(
    parameter int KEY_BYTES = vlc_pkg::KEY_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    vlc_req_if.sink                               i_req,
    vlc_rsp_if.source                             o_rsp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [vlc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [vlc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [vlc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    logic [vlc_pkg::APB_DATA_W-1:0] r_key [vlc_pkg::KEY_WORDS];
    logic [vlc_pkg::KEY_LEN_W-1:0]  r_key_len;
    logic [2:0]                     reg_idx;
    logic                           wr_en;
    logic [vlc_pkg::KEY_REG_BYTES*8-1:0] key_flat;

    vlc_pkg::t_work front_work;
    vlc_pkg::t_work q_work;
    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;

    // Register port: writes land in the access phase, no wait states.
    assign pready  = 1'b1;
    assign reg_idx = paddr[vlc_pkg::APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    assign key_flat = {r_key[3], r_key[2], r_key[1], r_key[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]  <= '0;
            r_key[1]  <= '0;
            r_key[2]  <= '0;
            r_key[3]  <= '0;
            r_key_len <= vlc_pkg::KEY_LEN_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                vlc_pkg::REG_KEY_WORD_0: r_key[0]  <= pwdata;
                vlc_pkg::REG_KEY_WORD_1: r_key[1]  <= pwdata;
                vlc_pkg::REG_KEY_WORD_2: r_key[2]  <= pwdata;
                vlc_pkg::REG_KEY_WORD_3: r_key[3]  <= pwdata;
                vlc_pkg::REG_KEY_LENGTH: r_key_len <= pwdata[vlc_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register; holes read as zero.
    always_comb begin
        case (reg_idx)
            vlc_pkg::REG_KEY_WORD_0: prdata = r_key[0];
            vlc_pkg::REG_KEY_WORD_1: prdata = r_key[1];
            vlc_pkg::REG_KEY_WORD_2: prdata = r_key[2];
            vlc_pkg::REG_KEY_WORD_3: prdata = r_key[3];
            vlc_pkg::REG_KEY_LENGTH: prdata = vlc_pkg::APB_DATA_W'(r_key_len);
            default:                 prdata = '0;
        endcase
    end

    // Front: take the request, pick the key shift, advance the position.
    vlc_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_key     (key_flat),
        .i_key_len (r_key_len),
        .i_q_full  (q_full),
        .o_work    (front_work),
        .o_push    (push)
    );

    vlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .i_pop   (pop),
        .o_work  (q_work),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // Back: rotate the letter inside its alphabet and register the result.
    vlc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (q_work),
        .i_valid (q_valid),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

@@ src/vlc_front.sv @@
// Front end: accept requests, track the key position, classify the byte.
`default_nettype none
module vlc_front #(
    parameter int KEY_BYTES = vlc_pkg::KEY_BYTES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    vlc_req_if.sink                                   i_req,
    input  wire logic [vlc_pkg::KEY_REG_BYTES*8-1:0]  i_key,
    input  wire logic [vlc_pkg::KEY_LEN_W-1:0]        i_key_len,
    input  wire logic                                 i_q_full,
    output vlc_pkg::t_work                            o_work,
    output logic                                      o_push
);
    localparam int POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [6:0]       len_raw;
    logic [6:0]       eff_len;
    logic [6:0]       pos_cur;
    logic [6:0]       pos_sel;
    logic [6:0]       pos_nxt;
    logic [7:0]       key_byte;
    logic [4:0]       shift;
    logic [7:0]       ch;

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;
    assign ch          = i_req.in_char;

    always_comb begin
        len_raw = {1'b0, i_key_len};
        if (len_raw == 7'd0) begin
            eff_len = 7'd1;
        end else if (len_raw > 7'(KEY_BYTES)) begin
            eff_len = 7'(KEY_BYTES);
        end else begin
            eff_len = len_raw;
        end
        pos_cur = i_req.restart ? 7'd0 : 7'(r_pos);
        // Drop back to zero when the length shrank under the position.
        pos_sel = (pos_cur >= eff_len) ? 7'd0 : pos_cur;
        pos_nxt = pos_sel + 7'd1;
        if (pos_nxt >= eff_len) begin
            pos_nxt = 7'd0;
        end
        n_pos = pos_nxt[POS_W-1:0];
    end

    always_comb begin
        if (pos_sel < 7'(vlc_pkg::KEY_REG_BYTES)) begin
            key_byte = i_key[pos_sel[4:0]*8 +: 8];
        end else begin
            key_byte = i_key[7:0];
        end
        if (pos_sel >= 7'(vlc_pkg::KEY_REG_BYTES)) begin
            shift = 5'd0;
        end else if (key_byte inside {[vlc_pkg::UPPER_A:vlc_pkg::UPPER_Z]}) begin
            shift = 5'(key_byte - vlc_pkg::UPPER_A);
        end else if (key_byte inside {[vlc_pkg::LOWER_A:vlc_pkg::LOWER_Z]}) begin
            shift = 5'(key_byte - vlc_pkg::LOWER_A);
        end else begin
            shift = 5'd0;
        end
    end

    always_comb begin
        o_work.action = i_req.action;
        o_work.ch     = ch;
        o_work.shift  = shift;
        if (ch inside {[vlc_pkg::UPPER_A:vlc_pkg::UPPER_Z]}) begin
            o_work.cls = vlc_pkg::CLS_UPPER;
            o_work.off = 5'(ch - vlc_pkg::UPPER_A);
        end else if (ch inside {[vlc_pkg::LOWER_A:vlc_pkg::LOWER_Z]}) begin
            o_work.cls = vlc_pkg::CLS_LOWER;
            o_work.off = 5'(ch - vlc_pkg::LOWER_A);
        end else begin
            o_work.cls = vlc_pkg::CLS_OTHER;
            o_work.off = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

@@ src/vlc_queue.sv @@
// Short request queue between front and back end.
`default_nettype none
module vlc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vlc_pkg::t_work i_work,
    input  wire logic           i_pop,
    output vlc_pkg::t_work      o_work,
    output logic                o_valid,
    output logic                o_full
);
    localparam int PTR_W = (vlc_pkg::QUEUE_DEPTH > 1) ? $clog2(vlc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(vlc_pkg::QUEUE_DEPTH + 1);

    vlc_pkg::t_work r_mem [vlc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(vlc_pkg::QUEUE_DEPTH));
    assign o_work  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(vlc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(vlc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/vlc_back.sv @@
// Back end: shift the letter with wraparound and hold the result register.
`default_nettype none
module vlc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire vlc_pkg::t_work i_work,
    input  wire logic           i_valid,
    output logic                o_pop,
    vlc_rsp_if.source           o_rsp
);
    logic       r_valid;
    logic [7:0] r_char;
    logic [7:0] n_char;
    logic [5:0] sum;
    logic [5:0] wrapped;

    assign o_pop          = i_valid && (!r_valid || o_rsp.ready);
    assign o_rsp.valid    = r_valid;
    assign o_rsp.out_char = r_char;

    always_comb begin
        if (i_work.action) begin
            sum = 6'(i_work.off) + 6'(vlc_pkg::ALPHA) - 6'(i_work.shift);
        end else begin
            sum = 6'(i_work.off) + 6'(i_work.shift);
        end
        wrapped = (sum >= 6'(vlc_pkg::ALPHA)) ? sum - 6'(vlc_pkg::ALPHA) : sum;
        case (i_work.cls)
            vlc_pkg::CLS_UPPER: n_char = vlc_pkg::UPPER_A + 8'(wrapped);
            vlc_pkg::CLS_LOWER: n_char = vlc_pkg::LOWER_A + 8'(wrapped);
            default:            n_char = i_work.ch;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char <= n_char;
        end
    end

endmodule
`default_nettype wire

@@ src/vlc_checker.sv @@
// Port-level checks of the letter cipher, bound to the top level.
`default_nettype none
module vlc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_char
);
    logic [2:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Count requests taken but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 3'd0)
        else $error("result without a pending request");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd3)
        else $error("more requests in flight than storage");

endmodule

bind vigenere_letter_cipher vlc_checker u_vlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_char  (o_rsp.out_char)
);
`default_nettype wire

@@ dv/vlc_tb_pkg.sv @@
// Scoreboard class that predicts and checks the cipher's output bytes.
`timescale 1ns / 100ps
package vlc_tb_pkg;

    import vlc_pkg::*;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    class cipher_scoreboard;
        logic [63:0] key_word [KEY_WORDS];
        logic [5:0]  key_len;
        int          key_pos;
        logic [7:0]  expected_chars [$];
        int          mismatch_count;

        function new();
            foreach (key_word[i]) key_word[i] = '0;
            key_len        = 6'd1;
            key_pos        = 0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            if (idx == REG_KEY_LENGTH) begin
                key_len = value[5:0];
            end else begin
                key_word[idx] = value;
            end
        endfunction

        // Shift of one key byte: letters give 0..25, anything else no shift.
        function int key_shift(int pos);
            logic [7:0] kb;
            kb = key_word[pos / 8][(pos % 8) * 8 +: 8];
            if (kb >= UPPER_A && kb <= UPPER_Z) return kb - UPPER_A;
            if (kb >= LOWER_A && kb <= LOWER_Z) return kb - LOWER_A;
            return 0;
        endfunction

        function void take_request(logic action, logic restart, logic [7:0] ch);
            int len;
            int pos;
            int shift;
            int base;
            int off;
            logic [7:0] res;
            len = (key_len == 0) ? 1 : ((key_len > KEY_REG_BYTES) ? KEY_REG_BYTES : key_len);
            pos = restart ? 0 : key_pos;
            // a position left beyond a shortened key starts over at zero
            if (pos >= len) pos = 0;
            shift = key_shift(pos);
            res   = ch;
            base  = -1;
            if (ch >= UPPER_A && ch <= UPPER_Z) base = UPPER_A;
            else if (ch >= LOWER_A && ch <= LOWER_Z) base = LOWER_A;
            if (base >= 0) begin
                off = ch - base;
                if (action == ACT_DECRYPT) off = (off + ALPHA - shift) % ALPHA;
                else off = (off + shift) % ALPHA;
                res = 8'(base + off);
            end
            pos = pos + 1;
            key_pos = (pos >= len) ? 0 : pos;
            expected_chars.push_back(res);
        endfunction

        function void check_out_char(logic [7:0] got);
            logic [7:0] want;
            if (expected_chars.size() == 0) begin
                if (mismatch_count < 10)
                    $display("ERROR: unexpected out_char %02h at %0t", got, $time);
                mismatch_count++;
                return;
            end
            want = expected_chars.pop_front();
            if (got !== want) begin
                if (mismatch_count < 10)
                    $display("ERROR: out_char expected %02h got %02h at %0t", want, got, $time);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function bit clean();
            return (mismatch_count == 0) && (expected_chars.size() == 0);
        endfunction
    endclass

endpackage

@@ dv/tb.sv @@
// Top-level testbench of the repeating-key letter cipher.
`timescale 1ns / 100ps
module tb;

    import vlc_pkg::*;
    import vlc_tb_pkg::*;

    localparam int ITEM_TARGET = 650;
    localparam int HOLD_CYCLES = 150;   // long back-pressure stretch on the result side
    localparam int HOLD_PHASE  = 2;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    vlc_req_if req_if ();
    vlc_rsp_if rsp_if ();

    vigenere_letter_cipher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cipher_scoreboard sb = new();

    int   phase_no   = 0;     // advanced by the stimulus, read by the hold-off process
    bit   req_steady = 0;     // request side sends back to back
    bit   rsp_steady = 0;     // result side never idles
    logic rsp_hold;           // long hold-off on the result side
    int   rsp_wait   = 0;
    int   sent_count = 0;

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Result side: check every accepted byte, then draw a fresh stall length.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_out_char(rsp_if.out_char);
                rsp_wait = rsp_steady ? 0 : $urandom_range(0, 12);
            end else if (rsp_wait > 0) begin
                rsp_wait--;
            end
            rsp_if.ready <= (rsp_wait == 0) && !rsp_hold;
        end
    end

    // Hold off the result side for a long stretch while the sender keeps
    // pushing, so the queue fills and the request side gets stalled.
    initial begin
        rsp_hold <= 1'b0;
        wait (phase_no == HOLD_PHASE);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    // Offer one request, hold it until taken, then note it for prediction.
    task automatic send_req(logic action, logic restart, logic [7:0] ch);
        int gap;
        gap = req_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.action  <= action;
        req_if.restart <= restart;
        req_if.in_char <= ch;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.take_request(action, restart, ch);
        sent_count++;
    endtask

    // Drop the request valid and wait until every predicted byte is back,
    // then hold off a while longer before touching the registers.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase until pready, then the bus goes idle.
    task automatic reg_write(logic [2:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Mostly letter key bytes of either case, some arbitrary bytes.
    function automatic logic [63:0] rand_key_word();
        logic [63:0] w;
        for (int b = 0; b < 8; b++) begin
            case ($urandom_range(0, 3))
                0:       w[b*8 +: 8] = 8'($urandom_range(0, 255));
                1:       w[b*8 +: 8] = UPPER_A + 8'($urandom_range(0, 25));
                default: w[b*8 +: 8] = LOWER_A + 8'($urandom_range(0, 25));
            endcase
        end
        return w;
    endfunction

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 4))
            0, 1:    return 8'($urandom_range(0, 255));
            2:       return UPPER_A + 8'($urandom_range(0, 25));
            default: return LOWER_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [5:0] rand_key_len();
        case ($urandom_range(0, 7))
            0:       return 6'd0;   // treated as one
            1:       return 6'd1;
            2:       return 6'd32;
            3:       return 6'd63;  // saturates to the full key
            4:       return 6'($urandom_range(33, 63));
            default: return 6'($urandom_range(1, 32));
        endcase
    endfunction

    initial begin
        logic [2:0] widx;
        int         n;

        req_if.valid   <= 1'b0;
        req_if.action  <= ACT_ENCRYPT;
        req_if.restart <= 1'b0;
        req_if.in_char <= 8'h00;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part. Key bytes 0..7: 'A' 'Z' 'a' 'z' '@' '[' '`' '{'
        // (both shift extremes, both cases, and non-letter neighbors).
        reg_write(REG_KEY_WORD_0, 64'h7B60_5B40_7A61_5A41);
        reg_write(REG_KEY_WORD_1, 64'h7E80_FF00_626D_424D);
        reg_write(REG_KEY_WORD_2, rand_key_word());
        reg_write(REG_KEY_WORD_3, rand_key_word());
        reg_write(REG_KEY_LENGTH, 64'd8);
        send_req(ACT_ENCRYPT, 1'b1, UPPER_A);
        send_req(ACT_ENCRYPT, 1'b0, UPPER_Z);   // shift 25 wraps
        send_req(ACT_DECRYPT, 1'b0, LOWER_A);
        send_req(ACT_DECRYPT, 1'b0, LOWER_Z);
        send_req(ACT_ENCRYPT, 1'b0, 8'h40);     // neighbors of the letter ranges
        send_req(ACT_ENCRYPT, 1'b0, 8'h5B);
        send_req(ACT_DECRYPT, 1'b0, 8'h60);
        send_req(ACT_DECRYPT, 1'b0, 8'h7B);
        send_req(ACT_ENCRYPT, 1'b0, 8'h00);     // position wrapped to zero
        send_req(ACT_DECRYPT, 1'b0, 8'hFF);
        send_req(ACT_ENCRYPT, 1'b0, 8'h80);
        send_req(ACT_DECRYPT, 1'b1, UPPER_Z);   // restart mid-key
        send_req(ACT_DECRYPT, 1'b0, UPPER_A);
        drain();
        // zero key length behaves like one
        reg_write(REG_KEY_LENGTH, 64'd0);
        send_req(ACT_ENCRYPT, 1'b0, LOWER_Z);
        send_req(ACT_ENCRYPT, 1'b0, UPPER_Z);
        drain();
        // oversize key length saturates; then leave the position past a shorter key
        reg_write(REG_KEY_LENGTH, 64'd63);
        for (int i = 0; i < 6; i++) send_req(i[0], 1'b0, LOWER_A + 8'(i * 5));
        drain();
        reg_write(REG_KEY_LENGTH, 64'd3);
        send_req(ACT_ENCRYPT, 1'b0, UPPER_Z);
        send_req(ACT_DECRYPT, 1'b0, LOWER_A);

        // Random phases, each with its own key setting and pacing.
        while (sent_count < ITEM_TARGET) begin
            drain();
            phase_no++;
            for (int w = 0; w < KEY_WORDS; w++) begin
                widx = 3'(w);
                if (phase_no == 1 || $urandom_range(0, 1) == 1)
                    reg_write(widx, rand_key_word());
            end
            reg_write(REG_KEY_LENGTH, 64'(rand_key_len()));
            req_steady = (phase_no == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            rsp_steady = (phase_no != HOLD_PHASE) && ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 90);
            for (int i = 0; i < n; i++)
                send_req(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0, rand_char());
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.clean()) begin
            $display("vigenere_letter_cipher test passed");
        end else begin
            $display("vigenere_letter_cipher test failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("vigenere_letter_cipher test failed");
        $finish;
    end

endmodule

@@ vigenere_letter_cipher.f @@
src/vlc_pkg.sv
src/vlc_ifs.sv
src/vlc_front.sv
src/vlc_queue.sv
src/vlc_back.sv
src/vigenere_letter_cipher.sv
src/vlc_checker.sv
dv/vlc_tb_pkg.sv
dv/tb.sv
